// File: src/sds_pkg.sv
`default_nettype none

package sds_pkg;

	// Operand capacity and derived widths
	localparam int MAX_DIGITS   = 64;
	localparam int DIG_AW       = $clog2(MAX_DIGITS);
	localparam int LEN_W        = $clog2(MAX_DIGITS + 1);
	localparam int DIGIT_W      = 4;
	localparam int DECIMAL_BASE = 10;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [LEN_W-1:0]   len_t;

	localparam digit_t DIGIT_MAX = digit_t'(DECIMAL_BASE - 1);

	// Datapath operations, one per microcode step
	typedef enum logic [3:0] {
		OP_LOAD,
		OP_INIT,
		OP_CMP_RD,
		OP_CMP_EV,
		OP_SUB_INIT,
		OP_SUB_RD,
		OP_SUB_EV,
		OP_EMIT_INIT,
		OP_EMIT_RD,
		OP_EMIT_PUSH,
		OP_CLEAR
	} op_t;

	// Jump conditions: taken means go to target, otherwise fall through
	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_NO_START,
		CND_P_ZERO,
		CND_P_EQ_N,
		CND_P_NOT_ONE
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE      = 4'd0;
	localparam step_t ST_INIT      = 4'd1;
	localparam step_t ST_CMP_RD    = 4'd2;
	localparam step_t ST_CMP_EV    = 4'd3;
	localparam step_t ST_SUB_INIT  = 4'd4;
	localparam step_t ST_SUB_RD    = 4'd5;
	localparam step_t ST_SUB_EV    = 4'd6;
	localparam step_t ST_EMIT_INIT = 4'd7;
	localparam step_t ST_EMIT_RD   = 4'd8;
	localparam step_t ST_EMIT_PUSH = 4'd9;
	localparam step_t ST_CLEAR     = 4'd10;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// Status from datapath to sequencer
	typedef struct packed {
		logic start;
		logic p_zero;
		logic p_eq_n;
		logic p_one;
		logic hold;
	} dp_flags_t;

	// Microcode ROM
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			ST_IDLE:      w = '{OP_LOAD,      CND_NO_START,  ST_IDLE};
			ST_INIT:      w = '{OP_INIT,      CND_ALWAYS,    ST_CMP_RD};
			ST_CMP_RD:    w = '{OP_CMP_RD,    CND_P_ZERO,    ST_SUB_INIT};
			ST_CMP_EV:    w = '{OP_CMP_EV,    CND_ALWAYS,    ST_CMP_RD};
			ST_SUB_INIT:  w = '{OP_SUB_INIT,  CND_ALWAYS,    ST_SUB_RD};
			ST_SUB_RD:    w = '{OP_SUB_RD,    CND_P_EQ_N,    ST_EMIT_INIT};
			ST_SUB_EV:    w = '{OP_SUB_EV,    CND_ALWAYS,    ST_SUB_RD};
			ST_EMIT_INIT: w = '{OP_EMIT_INIT, CND_ALWAYS,    ST_EMIT_RD};
			ST_EMIT_RD:   w = '{OP_EMIT_RD,   CND_ALWAYS,    ST_EMIT_PUSH};
			ST_EMIT_PUSH: w = '{OP_EMIT_PUSH, CND_P_NOT_ONE, ST_EMIT_RD};
			ST_CLEAR:     w = '{OP_CLEAR,     CND_ALWAYS,    ST_IDLE};
			default:      w = '{OP_CLEAR,     CND_ALWAYS,    ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: src/sds_in_if.sv
`default_nettype none

// Operand digit channel
interface sds_in_if;
	logic              valid;
	logic              ready;
	logic              kind;
	sds_pkg::digit_t   digit;
	logic              last;

	modport source (output valid, kind, digit, last, input ready);
	modport sink   (input valid, kind, digit, last, output ready);
endinterface

`default_nettype wire

// File: src/sds_out_if.sv
`default_nettype none

// Difference digit channel
interface sds_out_if;
	logic              valid;
	logic              ready;
	logic              negative;
	sds_pkg::digit_t   digit_out;
	logic              last_out;
	logic              overflow;

	modport source (output valid, negative, digit_out, last_out, overflow, input ready);
	modport sink   (input valid, negative, digit_out, last_out, overflow, output ready);
endinterface

`default_nettype wire

// File: src/sds_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read that holds while re is low
module sds_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/sds_sequencer.sv
`default_nettype none

// Step counter over the microcode ROM with conditional jumps
module sds_sequencer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sds_pkg::dp_flags_t  flags,
	output      sds_pkg::op_t        op
);
	import sds_pkg::*;

	step_t  step_q;
	uword_t uw;
	logic   taken;

	assign uw = ucode(step_q);
	assign op = uw.op;

	// Jump condition
	always_comb begin
		case (uw.cond)
			CND_ALWAYS:    taken = 1'b1;
			CND_NO_START:  taken = !flags.start;
			CND_P_ZERO:    taken = flags.p_zero;
			CND_P_EQ_N:    taken = flags.p_eq_n;
			CND_P_NOT_ONE: taken = !flags.p_one;
			default:       taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (!flags.hold) begin
			step_q <= taken ? uw.target : step_t'(step_q + 1'b1);
		end
	end

endmodule

`default_nettype wire

// File: src/signed_decimal_subtractor_core.sv
`default_nettype none

// Signed decimal subtractor.
// operand (sink): one decimal digit per transfer, most significant first;
//   kind 0 feeds the minuend, kind 1 the subtrahend. last on a subtrahend
//   digit closes the pair and starts the computation. Ready is high
//   only while the block is loading.
// result (source): the difference magnitude, most significant digit first,
//   leading zeros removed (a single zero is kept), each with the sign flag,
//   overflow flag and a last mark on the final digit.
// Flow, with n the longer operand length (at least 1): a microcoded
//   sequencer walks the n places of the stored digits through one read
//   port per number, comparing from the top place to find the sign, then
//   subtracting from the bottom into a difference store, then pushing the
//   digits out; a clear step follows before loading resumes.
// Digits above nine are stored as nine; digits beyond the capacity are
//   dropped and raise overflow for that pair.
// Reset clears lengths, flags, sequencer and the output valid flag; digit
//   stores are not cleared. A stalled receiver holds the result register
//   and the sequencer waits on it; nothing is lost.
module signed_decimal_subtractor_core (
	input  wire logic clk,
	input  wire logic arst_n,
	sds_in_if.sink    operand,
	sds_out_if.source result
);
	import sds_pkg::*;

	op_t       op;
	dp_flags_t flags;

	len_t   fst_len_q, snd_len_q, n_q, p_q, top_q;
	logic   ovf_q, lt_q, decided_q, borrow_q;
	logic   in_xfer, fst_we, snd_we, rd_en;
	digit_t din_sat, fst_rd, snd_rd, dif_rd;
	len_t   place, fst_idx, snd_idx, dif_idx;
	digit_t a_dig, b_dig, big, sml, diff;
	logic [DIGIT_W:0] small_w;
	logic   out_valid_q, out_neg_q, out_last_q, out_ovf_q, out_free;
	digit_t out_digit_q;

	// Input side
	assign operand.ready = (op == OP_LOAD);
	assign in_xfer       = operand.valid && operand.ready;
	assign din_sat       = (operand.digit > DIGIT_MAX) ? DIGIT_MAX : operand.digit;
	assign fst_we = in_xfer && !operand.kind && (fst_len_q < len_t'(MAX_DIGITS));
	assign snd_we = in_xfer && operand.kind && (snd_len_q < len_t'(MAX_DIGITS));

	// Place being worked on, counted from the least significant digit
	assign place   = (op inside {OP_CMP_RD, OP_CMP_EV}) ? len_t'(p_q - 1'b1) : p_q;
	assign fst_idx = len_t'(fst_len_q - 1'b1 - place);
	assign snd_idx = len_t'(snd_len_q - 1'b1 - place);
	assign dif_idx = len_t'(p_q - 1'b1);
	assign rd_en   = (op inside {OP_CMP_RD, OP_SUB_RD});

	sds_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_fst_ram (
		.clk   (clk),
		.we    (fst_we),
		.waddr (fst_len_q[DIG_AW-1:0]),
		.wdata (din_sat),
		.re    (rd_en),
		.raddr (fst_idx[DIG_AW-1:0]),
		.rdata (fst_rd)
	);

	sds_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_snd_ram (
		.clk   (clk),
		.we    (snd_we),
		.waddr (snd_len_q[DIG_AW-1:0]),
		.wdata (din_sat),
		.re    (rd_en),
		.raddr (snd_idx[DIG_AW-1:0]),
		.rdata (snd_rd)
	);

	sds_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_dif_ram (
		.clk   (clk),
		.we    (op == OP_SUB_EV),
		.waddr (p_q[DIG_AW-1:0]),
		.wdata (diff),
		.re    (op == OP_EMIT_RD),
		.raddr (dif_idx[DIG_AW-1:0]),
		.rdata (dif_rd)
	);

	// Digits above an operand's length read as zero
	assign a_dig = (place < fst_len_q) ? fst_rd : '0;
	assign b_dig = (place < snd_len_q) ? snd_rd : '0;

	// One digit of subtraction with borrow
	assign big     = lt_q ? b_dig : a_dig;
	assign sml     = lt_q ? a_dig : b_dig;
	assign small_w = {1'b0, sml} + {{DIGIT_W{1'b0}}, borrow_q};
	always_comb begin
		if ({1'b0, big} >= small_w) begin
			diff = digit_t'({1'b0, big} - small_w);
		end else begin
			diff = digit_t'({1'b0, big} + (DIGIT_W+1)'(DECIMAL_BASE) - small_w);
		end
	end

	// Sequencer status
	assign out_free     = !out_valid_q || result.ready;
	assign flags.start  = in_xfer && operand.kind && operand.last;
	assign flags.p_zero = (p_q == '0);
	assign flags.p_eq_n = (p_q == n_q);
	assign flags.p_one  = (p_q == len_t'(1));
	assign flags.hold   = (op == OP_EMIT_PUSH) && !out_free;

	sds_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_len_q <= '0;
			snd_len_q <= '0;
			ovf_q     <= 1'b0;
			n_q       <= '0;
			p_q       <= '0;
			top_q     <= '0;
			lt_q      <= 1'b0;
			decided_q <= 1'b0;
			borrow_q  <= 1'b0;
		end else begin
			case (op)
				OP_LOAD: begin
					if (in_xfer) begin
						if (fst_we) begin
							fst_len_q <= len_t'(fst_len_q + 1'b1);
						end else if (snd_we) begin
							snd_len_q <= len_t'(snd_len_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				OP_INIT: begin
					// n = max(lengths, 1); an empty pair still yields a zero
					if (fst_len_q >= snd_len_q && fst_len_q != '0) begin
						n_q <= fst_len_q;
						p_q <= fst_len_q;
					end else if (snd_len_q != '0) begin
						n_q <= snd_len_q;
						p_q <= snd_len_q;
					end else begin
						n_q <= len_t'(1);
						p_q <= len_t'(1);
					end
					lt_q      <= 1'b0;
					decided_q <= 1'b0;
				end
				OP_CMP_EV: begin
					// first differing place from the top decides the sign
					if (!decided_q && a_dig != b_dig) begin
						decided_q <= 1'b1;
						lt_q      <= (a_dig < b_dig);
					end
					p_q <= len_t'(p_q - 1'b1);
				end
				OP_SUB_INIT: begin
					p_q      <= '0;
					borrow_q <= 1'b0;
					top_q    <= len_t'(1);
				end
				OP_SUB_EV: begin
					borrow_q <= ({1'b0, big} < small_w);
					if (diff != '0) begin
						top_q <= len_t'(p_q + 1'b1);
					end
					p_q <= len_t'(p_q + 1'b1);
				end
				OP_EMIT_INIT: begin
					p_q <= top_q;
				end
				OP_EMIT_PUSH: begin
					if (out_free) begin
						p_q <= len_t'(p_q - 1'b1);
					end
				end
				OP_CLEAR: begin
					fst_len_q <= '0;
					snd_len_q <= '0;
					ovf_q     <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_EMIT_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EMIT_PUSH && out_free) begin
			out_neg_q   <= lt_q;
			out_digit_q <= dif_rd;
			out_last_q  <= flags.p_one;
			out_ovf_q   <= ovf_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.negative  = out_neg_q;
	assign result.digit_out = out_digit_q;
	assign result.last_out  = out_last_q;
	assign result.overflow  = out_ovf_q;

	// Checks
	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SUB_EV) |-> (p_q < n_q))
		else $error("subtract place beyond operand length");

	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EMIT_INIT) |-> (top_q != '0 && top_q <= n_q))
		else $error("result length out of range");

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.digit_out <= DIGIT_MAX))
		else $error("result digit is not decimal");

endmodule

`default_nettype wire

// File: tb/sv/sds_tb_pkg.sv
`default_nettype none

package sds_tb_pkg;

	// Which operand a digit transfer feeds
	localparam logic KIND_MINUEND    = 1'b0;
	localparam logic KIND_SUBTRAHEND = 1'b1;

	// Decimal number, most significant digit first
	typedef sds_pkg::digit_t digit_queue_t[$];

	// One digit of the difference as it leaves the block
	typedef struct packed {
		logic            negative;
		sds_pkg::digit_t digit;
		logic            last;
		logic            overflow;
	} diff_digit_t;

endpackage

`default_nettype wire

// File: tb/sv/difference_checker.sv
`default_nettype none

// Watches both channels, predicts the signed difference of each operand pair
// and compares every result transfer with the oldest predicted digit.
module difference_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	sds_in_if         operand,
	sds_out_if        result,
	output int        fail_count,
	output int        pending
);
	import sds_pkg::*;
	import sds_tb_pkg::*;

	digit_queue_t minuend_digits;
	digit_queue_t subtrahend_digits;
	logic         capacity_exceeded;
	diff_digit_t  expected_digits[$];

	initial begin
		fail_count        = 0;
		pending           = 0;
		capacity_exceeded = 1'b0;
	end

	// Digit at place p, counted from the least significant end; zero above the length
	function automatic int place_of(digit_queue_t num, int p);
		if (p >= num.size())
			return 0;
		return num[num.size() - 1 - p];
	endfunction

	// Magnitude compare, subtraction with borrow, zero strip, then queue the digits
	function automatic void compute_difference();
		int          n;
		int          p;
		int          top;
		int          cmp;
		int          a;
		int          b;
		int          big;
		int          sub;
		logic        neg;
		int          borrow;
		int          diff[MAX_DIGITS];
		diff_digit_t e;
		n = (minuend_digits.size() > subtrahend_digits.size()) ?
			minuend_digits.size() : subtrahend_digits.size();
		cmp = 0;
		for (p = n - 1; p >= 0 && cmp == 0; p--) begin
			a = place_of(minuend_digits, p);
			b = place_of(subtrahend_digits, p);
			if (a > b)
				cmp = 1;
			else if (a < b)
				cmp = -1;
		end
		neg = (cmp < 0);
		borrow = 0;
		for (p = 0; p < n; p++) begin
			a = place_of(minuend_digits, p);
			b = place_of(subtrahend_digits, p);
			big = neg ? b : a;
			sub = (neg ? a : b) + borrow;
			if (big >= sub) begin
				diff[p] = big - sub;
				borrow = 0;
			end else begin
				diff[p] = big + DECIMAL_BASE - sub;
				borrow = 1;
			end
		end
		top = n;
		while (top > 1 && diff[top-1] == 0)
			top--;
		if (top == 0) begin
			diff[0] = 0;
			top = 1;
		end
		for (p = top; p > 0; p--) begin
			e.negative = neg;
			e.digit    = digit_t'(diff[p-1]);
			e.last     = (p == 1);
			e.overflow = capacity_exceeded;
			expected_digits.push_back(e);
		end
		minuend_digits.delete();
		subtrahend_digits.delete();
		capacity_exceeded = 1'b0;
	endfunction

	// Store one accepted digit; a closing subtrahend digit triggers the compute
	function automatic void load_digit(logic kind, digit_t raw, logic last);
		digit_t d;
		d = (raw > DIGIT_MAX) ? DIGIT_MAX : raw;
		if (kind == KIND_MINUEND) begin
			if (minuend_digits.size() < MAX_DIGITS)
				minuend_digits.push_back(d);
			else
				capacity_exceeded = 1'b1;
		end else begin
			if (subtrahend_digits.size() < MAX_DIGITS)
				subtrahend_digits.push_back(d);
			else
				capacity_exceeded = 1'b1;
			if (last)
				compute_difference();
		end
	endfunction

	// Compare result transfers, then fold in operand transfers
	always @(posedge clk) begin
		diff_digit_t e;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_digits.size() == 0) begin
					$error("result transfer with no expected digit waiting");
					fail_count++;
				end else begin
					e = expected_digits.pop_front();
					if (result.negative !== e.negative) begin
						$error("negative mismatch: expected %0d, actual %0d",
							e.negative, result.negative);
						fail_count++;
					end
					if (result.digit_out !== e.digit) begin
						$error("digit_out mismatch: expected %0d, actual %0d",
							e.digit, result.digit_out);
						fail_count++;
					end
					if (result.last_out !== e.last) begin
						$error("last_out mismatch: expected %0d, actual %0d",
							e.last, result.last_out);
						fail_count++;
					end
					if (result.overflow !== e.overflow) begin
						$error("overflow mismatch: expected %0d, actual %0d",
							e.overflow, result.overflow);
						fail_count++;
					end
				end
			end
			if (operand.valid && operand.ready)
				load_digit(operand.kind, operand.digit, operand.last);
			pending <= expected_digits.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/signed_decimal_subtractor_core_test.sv
`default_nettype none

module signed_decimal_subtractor_core_test;
	import sds_pkg::*;
	import sds_tb_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 500;
	localparam int PHASE_ITEMS = 45;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_stall_pct;
	int   items_sent;
	int   idle_cycles;
	int   fail_count;
	int   pending;

	sds_in_if  operand_ch ();
	sds_out_if result_ch ();

	signed_decimal_subtractor_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_ch),
		.result  (result_ch)
	);

	difference_checker diff_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.operand    (operand_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Random number of the given length; now and then digits above nine
	function automatic digit_queue_t random_number(int len);
		digit_queue_t num;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				num.push_back(digit_t'($urandom_range(15, 10)));
			else
				num.push_back(digit_t'($urandom_range(9)));
		end
		return num;
	endfunction

	// Mostly short operands, a few long ones, rarely past capacity
	function automatic int random_length();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(6, 1);
		if (r < 90)
			return $urandom_range(20, 7);
		if (r < 97)
			return $urandom_range(MAX_DIGITS, 21);
		return $urandom_range(MAX_DIGITS + 4, MAX_DIGITS + 1);
	endfunction

	// One digit transfer; each cycle in front of it may be idle
	task automatic send_digit(logic kind, digit_t d, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			operand_ch.valid <= 1'b0;
			@(posedge clk);
		end
		operand_ch.valid <= 1'b1;
		operand_ch.kind  <= kind;
		operand_ch.digit <= d;
		operand_ch.last  <= last;
		do @(posedge clk); while (!operand_ch.ready);
		items_sent++;
	endtask

	task automatic send_number(logic kind, digit_queue_t num);
		for (int i = 0; i < num.size(); i++)
			send_digit(kind, num[i], i == num.size() - 1);
	endtask

	// Well-formed pair: minuend, then subtrahend closing on its last digit
	task automatic send_pair(digit_queue_t a, digit_queue_t b);
		send_number(KIND_MINUEND, a);
		send_number(KIND_SUBTRAHEND, b);
	endtask

	task automatic run_random_pair();
		digit_queue_t a;
		digit_queue_t b;
		int           sel;
		int           i;
		int           j;
		sel = $urandom_range(99);
		if (sel < 8) begin
			// noise: arbitrary kinds, digits and last marks
			repeat ($urandom_range(6, 1))
				send_digit(logic'($urandom_range(1)), digit_t'($urandom_range(15)),
					logic'($urandom_range(1)));
		end else begin
			if ($urandom_range(99) >= 5)
				a = random_number(random_length());
			if ($urandom_range(99) < 10 && a.size() != 0)
				b = a;
			else
				b = random_number(random_length());
			if ($urandom_range(99) < 10)
				repeat ($urandom_range(3, 1)) a.push_front(digit_t'(0));
			if (sel < 20) begin
				// interleaved kinds, stray last marks on the minuend
				i = 0;
				j = 0;
				while (i < a.size() || j < b.size() - 1) begin
					if (j >= b.size() - 1 || (i < a.size() && $urandom_range(1))) begin
						send_digit(KIND_MINUEND, a[i], logic'($urandom_range(1)));
						i++;
					end else begin
						send_digit(KIND_SUBTRAHEND, b[j], 1'b0);
						j++;
					end
				end
				send_digit(KIND_SUBTRAHEND, b[b.size()-1], 1'b1);
			end else begin
				send_pair(a, b);
			end
		end
	endtask

	// Receiver: one long hold-off after reset, then random stalls
	initial begin
		result_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		repeat (HOLD_CYCLES) @(posedge clk);
		forever begin
			result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			@(posedge clk);
		end
	end

	// Watchdog on cycles without any transfer
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus and verdict
	initial begin
		digit_queue_t a;
		digit_queue_t b;
		arst_n           <= 1'b0;
		operand_ch.valid <= 1'b0;
		operand_ch.kind  <= KIND_MINUEND;
		operand_ch.digit <= '0;
		operand_ch.last  <= 1'b0;
		items_sent   = 0;
		tx_idle_pct  = 16;
		rx_stall_pct = 60;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// minuend past capacity
		a = random_number(MAX_DIGITS + 1);
		a[0] = digit_t'(7);
		send_pair(a, '{digit_t'(5)});
		// subtrahend past capacity, result negative
		a = '{digit_t'(3), digit_t'(1), digit_t'(4)};
		b = random_number(MAX_DIGITS + 2);
		b[0] = digit_t'(9);
		send_pair(a, b);
		// empty minuend counts as zero; both stores are fully written by now
		send_number(KIND_SUBTRAHEND, '{digit_t'(7)});
		// equal numbers
		send_pair('{digit_t'(1), digit_t'(2), digit_t'(3)},
			'{digit_t'(1), digit_t'(2), digit_t'(3)});
		// leading zeros in the minuend
		send_pair('{digit_t'(0), digit_t'(0), digit_t'(4), digit_t'(2)}, '{digit_t'(5)});
		// digits above nine saturate
		send_pair('{digit_t'(15), digit_t'(12)}, '{digit_t'(0)});
		// last mark in the middle of the minuend has no effect
		send_digit(KIND_MINUEND, digit_t'(1), 1'b1);
		send_digit(KIND_MINUEND, digit_t'(2), 1'b0);
		send_digit(KIND_SUBTRAHEND, digit_t'(3), 1'b1);
		// zero minus zero, then borrow chains both ways
		send_pair('{digit_t'(0)}, '{digit_t'(0)});
		send_pair('{digit_t'(1), digit_t'(0), digit_t'(0), digit_t'(0)}, '{digit_t'(1)});
		send_pair('{digit_t'(1)}, '{digit_t'(1), digit_t'(0), digit_t'(0), digit_t'(0)});

		// random pairs over three idling phases
		items_sent = 0;
		while (items_sent < PHASE_ITEMS)
			run_random_pair();
		tx_idle_pct  = 60;
		rx_stall_pct = 16;
		while (items_sent < 2 * PHASE_ITEMS)
			run_random_pair();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		while (items_sent < 3 * PHASE_ITEMS)
			run_random_pair();
		// close any pair left open by noise
		send_digit(KIND_SUBTRAHEND, digit_t'(8), 1'b1);
		operand_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: signed_decimal_subtractor_core.f
src/sds_pkg.sv
src/sds_in_if.sv
src/sds_out_if.sv
src/sds_ram.sv
src/sds_sequencer.sv
src/signed_decimal_subtractor_core.sv
tb/sv/sds_tb_pkg.sv
tb/sv/difference_checker.sv
tb/sv/signed_decimal_subtractor_core_test.sv
